[design/mpc_pkg.sv]
// Package: constants, codes, state and command types for the multi-press counter
`default_nettype none
package mpc_pkg;
   localparam int BUTTONS = 4;
   localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   localparam logic [1:0] CMD_SHORT = 2'd0;
   localparam logic [1:0] CMD_MEDIUM = 2'd1;
   localparam logic [1:0] CMD_LONG = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;
   localparam logic [1:0] KIND_REPORT = 2'd3;

   localparam logic [7:0] COUNT_MAX = 8'hff;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [3:0] BUTTONS_W4 = 4'(BUTTONS);

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT,
      ST_NOTE,
      ST_BUMP
   } mpc_state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_NOTE,
      EMIT_SCAN,
      EMIT_SAT
   } mpc_emit_type;

   typedef struct packed {
      logic load;
      logic tick;
      logic hit_clear;
      logic scan;
      logic step;
      mpc_emit_type emit;
      logic bump;
      logic arm;
   } mpc_cmd_type;

   typedef struct packed {
      logic out_free;
      logic hit;
      logic is_tick;
      logic is_short;
      logic in_range;
      logic sat;
      logic idx_last;
      logic mask_bit;
      logic again;
   } mpc_status_type;
endpackage
`default_nettype wire

[design/mpc_if.sv]
// Interfaces: press/tick request, result and timeout register channels
`default_nettype none
interface mpc_req_if;
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [1:0] button;
   modport source (output valid, output cmd, output button, input ready);
   modport sink (input valid, input cmd, input button, output ready);
endinterface

interface mpc_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [1:0] button_id;
   logic [7:0] press_total;
   logic last;
   modport source (output valid, output kind, output button_id, output press_total,
                   output last, input ready);
   modport sink (input valid, input kind, input button_id, input press_total,
                 input last, output ready);
endinterface

interface mpc_csr_if;
   logic valid;
   logic ready;
   logic [15:0] timeout_ticks;
   modport source (output valid, output timeout_ticks, input ready);
   modport sink (input valid, input timeout_ticks, output ready);
endinterface
`default_nettype wire

[design/mpc_ctrl.sv]
// Controller: sequences decode, deadline scan and result emission
`default_nettype none
module mpc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  mpc_pkg::mpc_status_type status,
   output mpc_pkg::mpc_cmd_type command
);
   import mpc_pkg::*;

   mpc_state_type state_ff;
   mpc_state_type state_in;
   logic moved;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      command = '0;
      command.emit = EMIT_NONE;
      moved = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && req_ready) begin
               command.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_tick) begin
               command.tick = 1'b1;
               state_in = ST_CHECK;
            end else begin
               state_in = ST_NOTE;
            end
         end
         ST_CHECK: begin
            if (status.hit) begin
               command.hit_clear = 1'b1;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            command.scan = 1'b1;
            if (status.idx_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.mask_bit) begin
               moved = 1'b1;
            end else if (status.out_free) begin
               command.emit = EMIT_SCAN;
               moved = 1'b1;
            end
            command.step = moved;
            if (moved && status.idx_last) begin
               command.arm = status.again;
               state_in = ST_IDLE;
            end
         end
         ST_NOTE: begin
            if (status.out_free) begin
               command.emit = EMIT_NOTE;
               state_in = (status.is_short && status.in_range) ? ST_BUMP : ST_IDLE;
            end
         end
         ST_BUMP: begin
            if (status.sat) begin
               if (status.out_free) begin
                  command.emit = EMIT_SAT;
                  state_in = ST_IDLE;
               end
            end else begin
               command.bump = 1'b1;
               command.arm = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

[design/mpc_dp.sv]
// Datapath: press counters, stamps, clock, deadline and result register
`default_nettype none
module mpc_dp (
   input  logic clock,
   input  logic reset,
   input  logic [1:0] req_cmd,
   input  logic [1:0] req_button,
   mpc_csr_if.sink csr_ch,
   mpc_rsp_if.source rsp_ch,
   input  mpc_pkg::mpc_cmd_type command,
   output mpc_pkg::mpc_status_type status
);
   import mpc_pkg::*;

   logic [7:0] count_ff [BUTTONS];
   logic [7:0] count_in [BUTTONS];
   logic [31:0] stamp_ff [BUTTONS];
   logic [31:0] stamp_in [BUTTONS];
   logic [31:0] now_ff, now_in;
   logic [31:0] deadline_ff, deadline_in;
   logic armed_ff, armed_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [1:0] btn_ff, btn_in;
   idx_type idx_ff, idx_in;
   logic [BUTTONS-1:0] mask_ff, mask_in;
   logic again_ff, again_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [1:0] bid_ff, bid_in;
   logic [7:0] total_ff, total_in;
   logic last_ff, last_in;

   logic [31:0] eff_timeout;
   logic [31:0] age;
   logic [7:0] cur_count;
   logic active;
   logic eligible;
   logic above;
   logic out_free;
   logic idx_last;
   logic in_range;
   logic note_last;

   assign csr_ch.ready = !reset;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.kind = kind_ff;
   assign rsp_ch.button_id = bid_ff;
   assign rsp_ch.press_total = total_ff;
   assign rsp_ch.last = last_ff;

   assign eff_timeout = (timeout_ff == 16'd0) ? 32'd1 : {16'd0, timeout_ff};
   assign cur_count = count_ff[idx_ff];
   assign age = now_ff - stamp_ff[idx_ff];
   assign active = (cur_count != 8'd0);
   assign eligible = active && (age >= eff_timeout);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign idx_last = (idx_ff == IDX_W'(BUTTONS - 1));
   assign in_range = ({2'b00, btn_ff} < BUTTONS_W4);
   assign note_last = !((cmd_ff == CMD_SHORT) && in_range && (cur_count == COUNT_MAX - 8'd1));

   always_comb begin
      above = 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
         if (mask_ff[i] && (IDX_W'(i) > idx_ff)) begin
            above = 1'b1;
         end
      end
   end

   always_comb begin
      status.out_free = out_free;
      status.hit = armed_ff && (now_ff == deadline_ff);
      status.is_tick = (cmd_ff == CMD_TICK);
      status.is_short = (cmd_ff == CMD_SHORT);
      status.in_range = in_range;
      status.sat = (cur_count == COUNT_MAX - 8'd1);
      status.idx_last = idx_last;
      status.mask_bit = mask_ff[idx_ff];
      status.again = again_ff;
   end

   always_comb begin
      for (int i = 0; i < BUTTONS; i++) begin
         count_in[i] = count_ff[i];
         stamp_in[i] = stamp_ff[i];
      end
      now_in = now_ff;
      deadline_in = deadline_ff;
      armed_in = armed_ff;
      timeout_in = csr_ch.valid ? csr_ch.timeout_ticks : timeout_ff;
      cmd_in = cmd_ff;
      btn_in = btn_ff;
      idx_in = idx_ff;
      mask_in = mask_ff;
      again_in = again_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      kind_in = kind_ff;
      bid_in = bid_ff;
      total_in = total_ff;
      last_in = last_ff;

      if (command.load) begin
         cmd_in = req_cmd;
         btn_in = req_button;
         idx_in = IDX_W'(req_button);
      end
      if (command.tick) begin
         now_in = now_ff + 32'd1;
      end
      if (command.hit_clear) begin
         armed_in = 1'b0;
         mask_in = '0;
         again_in = 1'b0;
         idx_in = '0;
      end
      if (command.scan || command.step) begin
         idx_in = idx_last ? idx_type'(0) : idx_ff + idx_type'(1);
      end
      if (command.scan) begin
         mask_in[idx_ff] = eligible;
         if (active && !eligible) begin
            again_in = 1'b1;
         end
      end
      if (command.bump) begin
         count_in[idx_ff] = cur_count + 8'd1;
         stamp_in[idx_ff] = now_ff;
      end
      if (command.arm) begin
         deadline_in = now_ff + eff_timeout;
         armed_in = 1'b1;
      end

      case (command.emit)
         EMIT_NOTE: begin
            rsp_valid_in = 1'b1;
            kind_in = cmd_ff;
            bid_in = btn_ff;
            total_in = 8'd0;
            last_in = note_last;
         end
         EMIT_SCAN: begin
            rsp_valid_in = 1'b1;
            kind_in = KIND_REPORT;
            bid_in = 2'(idx_ff);
            total_in = cur_count;
            last_in = !above;
            count_in[idx_ff] = 8'd0;
            stamp_in[idx_ff] = 32'd0;
         end
         EMIT_SAT: begin
            rsp_valid_in = 1'b1;
            kind_in = KIND_REPORT;
            bid_in = 2'(idx_ff);
            total_in = COUNT_MAX;
            last_in = 1'b1;
            count_in[idx_ff] = 8'd0;
            stamp_in[idx_ff] = 32'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUTTONS; i++) begin
            count_ff[i] <= 8'd0;
            stamp_ff[i] <= 32'd0;
         end
         now_ff <= 32'd0;
         deadline_ff <= 32'd0;
         armed_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < BUTTONS; i++) begin
            count_ff[i] <= count_in[i];
            stamp_ff[i] <= stamp_in[i];
         end
         now_ff <= now_in;
         deadline_ff <= deadline_in;
         armed_ff <= armed_in;
         timeout_ff <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      btn_ff <= btn_in;
      idx_ff <= idx_in;
      mask_ff <= mask_in;
      again_ff <= again_in;
      kind_ff <= kind_in;
      bid_ff <= bid_in;
      total_ff <= total_in;
      last_ff <= last_in;
   end
endmodule
`default_nettype wire

[design/multi_press_counter_unit.sv]
// Top level: multi-press button counter, controller plus datapath
//
//   channel  dir   handshake                     word
//   req_ch   in    valid/ready                   cmd[1:0], button[1:0]
//   rsp_ch   out   valid/ready                   kind[1:0], button_id[1:0], press_total[7:0], last
//   csr_ch   in    valid/ready (=1 out of reset) timeout_ticks[15:0]
//
// Medium/long press: decode, then note; short press: decode, note, then bump; plain tick: decode, then check.
// Deadline tick: decode, check, then the one-entry-per-cycle scan followed by the
// report pass, one entry per cycle unless a stalled rsp_ch holds an emit step.
// One item at a time; results leave through a single output register.
// A stalled rsp_ch holds the sequencer in its current emit step.
// Synchronous reset clears counters, stamps, clock, deadline and the output valid.
`default_nettype none
module multi_press_counter_unit (
   input  logic clock,
   input  logic reset,
   mpc_req_if.sink req_ch,
   mpc_rsp_if.source rsp_ch,
   mpc_csr_if.sink csr_ch
);
   import mpc_pkg::*;

   mpc_cmd_type command;
   mpc_status_type status;

   mpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .command   (command)
   );

   mpc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_ch.cmd),
      .req_button (req_ch.button),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch),
      .command    (command),
      .status     (status)
   );
endmodule
`default_nettype wire

[verif/tb_multi_press_counter_unit.sv]
// Testbench: multi-press counter checked word by word against a behavioral predictor
module tb_multi_press_counter_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mpc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS = 24;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] button_id;
      logic [7:0] press_total;
      logic last;
   } press_word_t;

   typedef enum logic [1:0] {ROW_PRESS, ROW_TIMEOUT, ROW_DRAIN} row_op_t;

   typedef struct packed {
      row_op_t op;
      logic [1:0] cmd;
      logic [1:0] button;
      logic [15:0] timeout_value;
      logic typed;
      press_word_t want;
   } stim_row_t;

   localparam press_word_t NO_WORD = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpc_req_if req_ch ();
   mpc_rsp_if rsp_ch ();
   mpc_csr_if csr_ch ();

   multi_press_counter_unit dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [7:0] press_count [BUTTONS];
   logic [31:0] press_stamp [BUTTONS];
   logic [31:0] now_ticks = '0;
   logic [31:0] deadline = '0;
   logic deadline_armed = 1'b0;
   logic [15:0] quiet_ticks = TIMEOUT_RESET;

   press_word_t due_words [$];
   stim_row_t directed_rows [0:24];

   bit idle_on = 1'b1;
   int fail_count = 0;
   int items_sent = 0;
   int words_checked = 0;
   int reports_checked = 0;
   int cycles_run = 0;

   function automatic bit counts_pending();
      foreach (press_count[i]) begin
         if (press_count[i] != 8'd0) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic count_presses(input logic [1:0] cmd, input logic [1:0] btn, input bit post);
      press_word_t made [$];
      logic [31:0] span;
      logic [31:0] age;
      bit again;
      span = (quiet_ticks == 16'd0) ? 32'd1 : {16'd0, quiet_ticks};
      if (cmd == CMD_TICK) begin
         now_ticks = now_ticks + 32'd1;
         if (deadline_armed && now_ticks == deadline) begin
            deadline_armed = 1'b0;
            again = 1'b0;
            for (int i = 0; i < BUTTONS; i++) begin
               if (press_count[i] != 8'd0) begin
                  age = now_ticks - press_stamp[i];
                  if (age >= span) begin
                     made.push_back('{KIND_REPORT, 2'(i), press_count[i], 1'b0});
                     press_count[i] = 8'd0;
                     press_stamp[i] = '0;
                  end else begin
                     again = 1'b1;
                  end
               end
            end
            if (again) begin
               deadline = now_ticks + span;
               deadline_armed = 1'b1;
            end
         end
      end else if (cmd == CMD_SHORT) begin
         made.push_back('{CMD_SHORT, btn, 8'd0, 1'b0});
         if (btn < BUTTONS) begin
            press_count[btn] = press_count[btn] + 8'd1;
            if (press_count[btn] == COUNT_MAX) begin
               made.push_back('{KIND_REPORT, btn, COUNT_MAX, 1'b0});
               press_count[btn] = 8'd0;
               press_stamp[btn] = '0;
            end else begin
               press_stamp[btn] = now_ticks;
               deadline = now_ticks + span;
               deadline_armed = 1'b1;
            end
         end
      end else begin
         made.push_back('{cmd, btn, 8'd0, 1'b0});
      end
      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      if (post) begin
         foreach (made[i]) due_words.push_back(made[i]);
      end
   endtask

   // starts and ends on a falling edge; valid stays high for the next word
   task automatic send_press(input logic [1:0] cmd, input logic [1:0] btn, input bit typed,
                             input press_word_t want);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.button <= btn;
      do @(posedge clock); while (!req_ch.ready);
      count_presses(cmd, btn, !typed);
      if (typed) due_words.push_back(want);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] value);
      req_ch.valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.timeout_ticks <= value;
      do @(posedge clock); while (!csr_ch.ready);
      quiet_ticks = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic tick_until_reported();
      while (counts_pending()) send_press(CMD_TICK, 2'($urandom_range(0, 3)), 1'b0, NO_WORD);
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      press_word_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_words.size() == 0) begin
            $error("unexpected word: kind %0d button_id %0d press_total %0d last %0d",
                   rsp_ch.kind, rsp_ch.button_id, rsp_ch.press_total, rsp_ch.last);
            fail_count++;
         end else begin
            want = due_words.pop_front();
            if (rsp_ch.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_ch.kind);
               fail_count++;
            end
            if (rsp_ch.button_id !== want.button_id) begin
               $error("button_id: expected %0d, got %0d", want.button_id, rsp_ch.button_id);
               fail_count++;
            end
            if (rsp_ch.press_total !== want.press_total) begin
               $error("press_total: expected %0d, got %0d", want.press_total,
                      rsp_ch.press_total);
               fail_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
               fail_count++;
            end
            words_checked++;
            if (want.kind == KIND_REPORT) reports_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int roll;
      logic [1:0] cmd;
      logic [1:0] sat_btn;
      logic [15:0] phase_timeout [5];

      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_SHORT;
      req_ch.button = 2'd0;
      csr_ch.valid = 1'b0;
      csr_ch.timeout_ticks = 16'd0;
      foreach (press_count[i]) begin
         press_count[i] = 8'd0;
         press_stamp[i] = '0;
      end
      phase_timeout = '{16'd1, 16'd0, 16'd5, 16'd12, 16'd3};

      directed_rows = '{
         '{ROW_PRESS, CMD_MEDIUM, 2'd0, 16'd0, 1'b1, '{CMD_MEDIUM, 2'd0, 8'd0, 1'b1}},
         '{ROW_PRESS, CMD_MEDIUM, 2'd3, 16'd0, 1'b1, '{CMD_MEDIUM, 2'd3, 8'd0, 1'b1}},
         '{ROW_PRESS, CMD_LONG, 2'd1, 16'd0, 1'b1, '{CMD_LONG, 2'd1, 8'd0, 1'b1}},
         '{ROW_PRESS, CMD_LONG, 2'd2, 16'd0, 1'b1, '{CMD_LONG, 2'd2, 8'd0, 1'b1}},
         '{ROW_PRESS, CMD_TICK, 2'd3, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_SHORT, 2'd0, 16'd0, 1'b1, '{CMD_SHORT, 2'd0, 8'd0, 1'b1}},
         '{ROW_PRESS, CMD_SHORT, 2'd0, 16'd0, 1'b1, '{CMD_SHORT, 2'd0, 8'd0, 1'b1}},
         '{ROW_PRESS, CMD_SHORT, 2'd3, 16'd0, 1'b1, '{CMD_SHORT, 2'd3, 8'd0, 1'b1}},
         '{ROW_PRESS, CMD_TICK, 2'd0, 16'd0, 1'b0, NO_WORD},
         '{ROW_TIMEOUT, CMD_TICK, 2'd0, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_SHORT, 2'd1, 16'd0, 1'b0, NO_WORD},
         '{ROW_DRAIN, CMD_TICK, 2'd0, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_TICK, 2'd2, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_SHORT, 2'd2, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_SHORT, 2'd2, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_SHORT, 2'd0, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_TICK, 2'd1, 16'd0, 1'b0, NO_WORD},
         '{ROW_TIMEOUT, CMD_TICK, 2'd0, 16'd2, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_SHORT, 2'd3, 16'd0, 1'b0, NO_WORD},
         '{ROW_TIMEOUT, CMD_TICK, 2'd0, 16'd40, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_TICK, 2'd0, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_TICK, 2'd3, 16'd0, 1'b0, NO_WORD},
         '{ROW_TIMEOUT, CMD_TICK, 2'd0, 16'd1, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_SHORT, 2'd0, 16'd0, 1'b0, NO_WORD},
         '{ROW_PRESS, CMD_TICK, 2'd2, 16'd0, 1'b0, NO_WORD}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         case (directed_rows[r].op)
            ROW_PRESS: send_press(directed_rows[r].cmd, directed_rows[r].button,
                                  directed_rows[r].typed, directed_rows[r].want);
            ROW_TIMEOUT: set_timeout(directed_rows[r].timeout_value);
            default: tick_until_reported();
         endcase
      end

      // arm far out at the widest quiet time, then pull the deadline in with a short one
      idle_on = 1'b0;
      set_timeout(16'hffff);
      send_press(CMD_SHORT, 2'd2, 1'b0, NO_WORD);
      send_press(CMD_SHORT, 2'd1, 1'b0, NO_WORD);
      send_press(CMD_MEDIUM, 2'd0, 1'b0, NO_WORD);
      repeat (3) send_press(CMD_TICK, 2'd0, 1'b0, NO_WORD);
      set_timeout(16'd2);
      send_press(CMD_SHORT, 2'd1, 1'b0, NO_WORD);
      tick_until_reported();
      idle_on = 1'b1;

      set_timeout(16'($urandom_range(3, 6)));
      sat_btn = 2'($urandom_range(0, 3));
      send_press(CMD_SHORT, sat_btn + 2'd1, 1'b0, NO_WORD);
      repeat (255) send_press(CMD_SHORT, sat_btn, 1'b0, NO_WORD);
      tick_until_reported();

      for (int p = 0; p < 5; p++) begin
         if (p == 4) idle_on = 1'b0;
         set_timeout(p == 3 ? 16'($urandom_range(2, 12)) : phase_timeout[p]);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 19) == 0) wait_drained();
            roll = $urandom_range(0, 99);
            cmd = (roll < 40) ? CMD_SHORT : (roll < 85) ? CMD_TICK :
                  (roll < 93) ? CMD_MEDIUM : CMD_LONG;
            send_press(cmd, 2'($urandom_range(0, 3)), 1'b0, NO_WORD);
         end
         tick_until_reported();
      end

      req_ch.valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d request words sent, %0d result words checked, %0d of them count reports",
               items_sent, words_checked, reports_checked);
      $display("quiet times 0 to 40 plus a 65535 arm, deadline re-arm and 255-press rollover run");
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[multi_press_counter_unit.f]
design/mpc_pkg.sv
design/mpc_if.sv
design/mpc_ctrl.sv
design/mpc_dp.sv
design/multi_press_counter_unit.sv
verif/tb_multi_press_counter_unit.sv
